FILE: src/gjs_pkg.sv
package gjs_pkg;

  localparam int unsigned DEF_MAX_ROWS    = 16;
  localparam int unsigned DEF_MAX_COLUMNS = 16;
  localparam int unsigned VAL_W           = 32;
  localparam int unsigned CFG_W           = 5;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned ROW_ID_W        = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

  typedef enum logic [3:0] {
    DP_NOP   = 4'd0,
    DP_LOAD  = 4'd1,
    DP_RDA   = 4'd2,
    DP_RDB   = 4'd3,
    DP_WRA   = 4'd4,
    DP_WRB   = 4'd5,
    DP_DIV   = 4'd6,
    DP_MUL   = 4'd7,
    DP_SUB   = 4'd8
  } dp_op_t;

  function automatic logic [VAL_W-1:0] mag32(input logic signed [VAL_W-1:0] v);
    logic [VAL_W-1:0] r;
    r = v[VAL_W-1] ? (~v + 1'b1) : v;
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] sat64(input logic signed [63:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -64'sh0000_0000_8000_0000) r = 32'sh8000_0000;
    else r = v[VAL_W-1:0];
    return r;
  endfunction

endpackage

FILE: src/gjs_if.sv
interface gjs_in_if;
  import gjs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] element_value;
  logic                    last_element;
  modport source (output valid, element_value, last_element, input ready);
  modport sink   (input valid, element_value, last_element, output ready);
endinterface

interface gjs_out_if;
  import gjs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] solution_value;
  logic [ROW_ID_W-1:0]     row_index;
  logic                    last_result;
  logic                    singular;
  modport source (output valid, solution_value, row_index, last_result, singular,
                  input ready);
  modport sink   (input valid, solution_value, row_index, last_result, singular,
                  output ready);
endinterface

FILE: src/gjs_divider.sv
module gjs_divider
  import gjs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [VAL_W-1:0] num,
  input  logic signed [VAL_W-1:0] den,
  output logic                    done,
  output logic signed [VAL_W-1:0] quo
);

  localparam int unsigned DW = 48;
  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0]  rem_r, rem_nxt;
  logic [DW-1:0]  q_r, q_nxt;
  logic [VAL_W-1:0] d_r, d_nxt;
  logic           neg_r, neg_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic [DW:0]    trial;
  logic signed [63:0] sq;

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r, q_r[DW-1]} - {{(DW+1-VAL_W){1'b0}}, d_r};
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = {mag32(num), 16'd0};
      d_nxt    = mag32(den);
      neg_nxt  = num[VAL_W-1] ^ den[VAL_W-1];
      cnt_nxt  = CW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[DW]) begin
        rem_nxt = trial[DW-1:0];
        q_nxt   = {q_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DW-2:0], q_r[DW-1]};
        q_nxt   = {q_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    d_r   <= d_nxt;
    neg_r <= neg_nxt;
  end

  assign sq   = neg_r ? -$signed({16'd0, q_r}) : $signed({16'd0, q_r});
  assign quo  = sat64(sq);
  assign done = !busy_r && !start;

endmodule

FILE: src/gjs_datapath.sv
module gjs_datapath
  import gjs_pkg::*;
#(
  parameter int unsigned MAX_ROWS    = DEF_MAX_ROWS,
  parameter int unsigned MAX_COLUMNS = DEF_MAX_COLUMNS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_op_t                  op,
  input  logic [$clog2(MAX_ROWS*MAX_COLUMNS)-1:0] addr,
  input  logic signed [VAL_W-1:0] din,
  output logic signed [VAL_W-1:0] a_q,
  output logic signed [VAL_W-1:0] b_q,
  output logic signed [VAL_W-1:0] rd_q,
  output logic                    busy
);

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] a_r, b_r, rd_r;
  logic signed [63:0]      prod_r;
  logic                    div_start;
  logic                    div_done;
  logic signed [VAL_W-1:0] div_q;
  logic                    div_pend_r;
  logic                    mem_we;
  logic signed [VAL_W-1:0] mem_wd;
  logic signed [63:0]      prod_sh;

  assign div_start = (op == DP_DIV);
  assign prod_sh   = prod_r >>> 16;

  gjs_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (a_r),
    .den   (b_r),
    .done  (div_done),
    .quo   (div_q)
  );

  always_comb begin
    mem_we = 1'b0;
    mem_wd = din;
    unique case (op)
      DP_LOAD: begin
        mem_we = 1'b1;
        mem_wd = din;
      end
      DP_WRA: begin
        mem_we = 1'b1;
        mem_wd = a_r;
      end
      DP_WRB: begin
        mem_we = 1'b1;
        mem_wd = b_r;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[addr] <= mem_wd;
    rd_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_pend_r <= 1'b0;
    end else if (div_start) begin
      div_pend_r <= 1'b1;
    end else if (div_pend_r && div_done) begin
      div_pend_r <= 1'b0;
    end
    unique case (op)
      DP_RDA: a_r <= rd_r;
      DP_RDB: b_r <= rd_r;
      DP_MUL: prod_r <= 64'(a_r) * 64'(b_r);
      DP_SUB: a_r <= sat64(64'(a_r) - ((prod_r < 0 && prod_r[15:0] != 16'd0) ?
                                       prod_sh + 64'sd1 : prod_sh));
      default: begin
        if (div_pend_r && div_done) a_r <= div_q;
      end
    endcase
  end

  assign a_q  = a_r;
  assign b_q  = b_r;
  assign rd_q = rd_r;
  assign busy = div_start || (div_pend_r && !div_done) || (div_pend_r && div_done);

endmodule

FILE: src/gjs_ctrl.sv
module gjs_ctrl
  import gjs_pkg::*;
#(
  parameter int unsigned MAX_ROWS    = DEF_MAX_ROWS,
  parameter int unsigned MAX_COLUMNS = DEF_MAX_COLUMNS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_last,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ROW_ID_W-1:0]     out_row,
  output logic                    out_last,
  output logic                    out_sing,
  output logic                    out_load,
  output dp_op_t                  op,
  output logic [$clog2(MAX_ROWS*MAX_COLUMNS)-1:0] addr,
  input  logic signed [VAL_W-1:0] a_q,
  input  logic signed [VAL_W-1:0] b_q,
  input  logic signed [VAL_W-1:0] rd_q,
  input  logic                    dp_busy
);

  localparam int unsigned AW  = $clog2(MAX_ROWS*MAX_COLUMNS);
  localparam int unsigned RW  = $clog2(MAX_ROWS + 1);
  localparam int unsigned CW  = $clog2(MAX_COLUMNS + 1);

  typedef enum logic [17:0] {
    S_LOAD   = 18'b000000000000000001,
    S_PVRD   = 18'b000000000000000010,
    S_PVCMP  = 18'b000000000000000100,
    S_SWRA   = 18'b000000000000001000,
    S_SWRB   = 18'b000000000000010000,
    S_SWWA   = 18'b000000000000100000,
    S_SWWB   = 18'b000000000001000000,
    S_PRD    = 18'b000000000010000000,
    S_PCHK   = 18'b000000000100000000,
    S_SCRD   = 18'b000000001000000000,
    S_SCDIV  = 18'b000000010000000000,
    S_SCWAIT = 18'b000000100000000000,
    S_FRD    = 18'b000001000000000000,
    S_ELRD   = 18'b000010000000000000,
    S_ELMUL  = 18'b000100000000000000,
    S_ELSUB  = 18'b001000000000000000,
    S_OUTRD  = 18'b010000000000000000,
    S_OUT    = 18'b100000000000000000
  } st_t;

  st_t st_r, st_nxt;
  logic [CFG_W-1:0] rows_cfg_r, cols_cfg_r;
  logic [RW-1:0] nr_r, nr_nxt;
  logic [CW-1:0] nc_r, nc_nxt;
  logic [RW-1:0] nr_now;
  logic [CW-1:0] nc_now;
  logic [AW:0]   pos_r, pos_nxt;
  logic [AW:0]   lrow_r, lrow_nxt;
  logic [AW:0]   lcol_r, lcol_nxt;
  logic [RW-1:0] i_r, i_nxt, k_r, k_nxt, best_r, best_nxt;
  logic [CW-1:0] l_r, l_nxt;
  logic [VAL_W-1:0] bmag_r, bmag_nxt;
  logic [1:0]    ph_r, ph_nxt;
  logic          sing_r, sing_nxt;
  logic [RW-1:0] lim;
  logic          take;

  function automatic logic [AW-1:0] ad(input logic [RW-1:0] r, input logic [CW-1:0] c);
    logic [AW+RW+CW-1:0] t;
    t = (AW+RW+CW)'(r) * (AW+RW+CW)'(MAX_COLUMNS) + (AW+RW+CW)'(c);
    return t[AW-1:0];
  endfunction

  always_comb begin
    nr_now = (rows_cfg_r == '0) ? RW'(1) :
             ((32'(rows_cfg_r) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(rows_cfg_r));
    nc_now = (cols_cfg_r < CFG_W'(2)) ? CW'(2) :
             ((32'(cols_cfg_r) > MAX_COLUMNS) ? CW'(MAX_COLUMNS) : CW'(cols_cfg_r));
  end

  assign lim  = (32'(nr_r) < 32'(nc_r)) ? nr_r : RW'(nc_r);
  assign take = in_valid && in_ready;
  assign in_ready  = (st_r == S_LOAD) && (32'(lcol_r) < 32'(nc_now));
  assign out_valid = (st_r == S_OUT);
  assign out_row   = ROW_ID_W'(k_r);
  assign out_last  = (k_r + 1'b1 == nr_r);
  assign out_sing  = sing_r;

  always_comb begin
    st_nxt = st_r; nr_nxt = nr_r; nc_nxt = nc_r;
    pos_nxt = pos_r; lrow_nxt = lrow_r; lcol_nxt = lcol_r;
    i_nxt = i_r; k_nxt = k_r; best_nxt = best_r; l_nxt = l_r;
    bmag_nxt = bmag_r; ph_nxt = ph_r; sing_nxt = sing_r;
    op = DP_NOP; addr = '0; out_load = 1'b0;
    unique case (st_r)
      S_LOAD: begin
        addr = ad(RW'(lrow_r), CW'(lcol_r));
        if (take) begin
          if (32'(pos_r) < 32'(nr_now) * 32'(nc_now)) begin
            op = DP_LOAD;
            out_load = 1'b1;
            pos_nxt = pos_r + 1'b1;
            if (32'(lcol_r) + 1 == 32'(nc_now)) begin
              lcol_nxt = '0;
              lrow_nxt = lrow_r + 1'b1;
            end else begin
              lcol_nxt = lcol_r + 1'b1;
            end
          end
          if (in_last) begin
            nr_nxt = nr_now; nc_nxt = nc_now; sing_nxt = 1'b0;
            pos_nxt = '0; lrow_nxt = '0; lcol_nxt = '0;
            i_nxt = '0; best_nxt = '0; k_nxt = '0; ph_nxt = '0;
            st_nxt = S_PVRD;
          end
        end else if (32'(lcol_r) >= 32'(nc_now)) begin
          // split the load position into row and column after a shape change
          lcol_nxt = lcol_r - (AW+1)'(nc_now);
          lrow_nxt = lrow_r + 1'b1;
        end
      end
      S_PVRD: begin
        if (i_r == lim) begin
          k_nxt = '0; ph_nxt = '0; st_nxt = S_OUTRD;
        end else begin
          addr = ad(k_r, CW'(i_r));
          if (ph_r == 2'd0) begin
            ph_nxt = 2'd1;
          end else begin
            ph_nxt = 2'd0; st_nxt = S_PVCMP;
          end
        end
      end
      S_PVCMP: begin
        if (k_r == i_r) begin
          best_nxt = i_r; bmag_nxt = mag32(rd_q);
        end else if (mag32(rd_q) > bmag_r) begin
          best_nxt = k_r; bmag_nxt = mag32(rd_q);
        end
        if (k_r + 1'b1 == nr_r) begin
          l_nxt = '0;
          st_nxt = ((k_r == i_r) ? i_r : ((mag32(rd_q) > bmag_r) ? k_r : best_r)) != i_r ?
                   S_SWRA : S_PRD;
        end else begin
          k_nxt = k_r + 1'b1; st_nxt = S_PVRD;
        end
        if (k_r == '0 && i_r != '0) begin
          k_nxt = i_r; st_nxt = S_PVRD;
        end
      end
      S_SWRA: begin
        addr = ad(best_r, l_r);
        if (ph_r == 2'd0) ph_nxt = 2'd1;
        else begin
          op = DP_RDA; ph_nxt = 2'd0; st_nxt = S_SWRB;
        end
      end
      S_SWRB: begin
        addr = ad(i_r, l_r);
        if (ph_r == 2'd0) ph_nxt = 2'd1;
        else begin
          op = DP_RDB; ph_nxt = 2'd0; st_nxt = S_SWWA;
        end
      end
      S_SWWA: begin
        addr = ad(i_r, l_r); op = DP_WRA; st_nxt = S_SWWB;
      end
      S_SWWB: begin
        addr = ad(best_r, l_r); op = DP_WRB;
        if (l_r + 1'b1 == nc_r) begin
          l_nxt = '0; st_nxt = S_PRD;
        end else begin
          l_nxt = l_r + 1'b1; st_nxt = S_SWRA;
        end
      end
      S_PRD: begin
        addr = ad(i_r, CW'(i_r));
        if (ph_r == 2'd0) ph_nxt = 2'd1;
        else begin
          op = DP_RDB; ph_nxt = 2'd0; st_nxt = S_PCHK;
        end
      end
      S_PCHK: begin
        l_nxt = '0;
        if (b_q == '0) begin
          sing_nxt = 1'b1; i_nxt = i_r + 1'b1; k_nxt = '0; st_nxt = S_PVRD;
        end else begin
          st_nxt = S_SCRD;
        end
      end
      S_SCRD: begin
        addr = ad(i_r, l_r);
        if (ph_r == 2'd0) ph_nxt = 2'd1;
        else begin
          op = DP_RDA; ph_nxt = 2'd0; st_nxt = S_SCDIV;
        end
      end
      S_SCDIV: begin
        op = DP_DIV; st_nxt = S_SCWAIT;
      end
      S_SCWAIT: begin
        addr = ad(i_r, l_r);
        if (!dp_busy) begin
          op = DP_WRA;
          if (l_r + 1'b1 == nc_r) begin
            l_nxt = '0; k_nxt = '0; st_nxt = S_FRD;
          end else begin
            l_nxt = l_r + 1'b1; st_nxt = S_SCRD;
          end
        end
      end
      S_FRD: begin
        if (k_r == nr_r) begin
          i_nxt = i_r + 1'b1; k_nxt = '0; st_nxt = S_PVRD;
        end else if (k_r == i_r) begin
          k_nxt = k_r + 1'b1;
        end else begin
          addr = ad(k_r, CW'(i_r));
          if (ph_r == 2'd0) ph_nxt = 2'd1;
          else begin
            op = DP_RDB; ph_nxt = 2'd0; l_nxt = '0; st_nxt = S_ELRD;
          end
        end
      end
      S_ELRD: begin
        addr = ad(i_r, l_r);
        if (ph_r == 2'd0) ph_nxt = 2'd1;
        else begin
          op = DP_RDA; ph_nxt = 2'd0; st_nxt = S_ELMUL;
        end
      end
      S_ELMUL: begin
        op = DP_MUL; st_nxt = S_ELSUB;
      end
      S_ELSUB: begin
        addr = ad(k_r, l_r);
        unique case (ph_r)
          2'd0: ph_nxt = 2'd1;
          2'd1: begin
            op = DP_RDA; ph_nxt = 2'd2;
          end
          2'd2: begin
            op = DP_SUB; ph_nxt = 2'd3;
          end
          default: begin
            op = DP_WRA; ph_nxt = '0;
            if (l_r + 1'b1 == nc_r) begin
              l_nxt = '0; k_nxt = k_r + 1'b1; st_nxt = S_FRD;
            end else begin
              l_nxt = l_r + 1'b1; st_nxt = S_ELRD;
            end
          end
        endcase
      end
      S_OUTRD: begin
        addr = ad(k_r, nc_r - 1'b1);
        if (ph_r == 2'd0) ph_nxt = 2'd1;
        else begin
          ph_nxt = 2'd0; st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          if (k_r + 1'b1 == nr_r) begin
            k_nxt = '0; st_nxt = S_LOAD;
          end else begin
            k_nxt = k_r + 1'b1; st_nxt = S_OUTRD;
          end
        end
      end
      default: st_nxt = S_LOAD;
    endcase
    if (cfg_we) begin
      lrow_nxt = '0;
      lcol_nxt = pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD;
      rows_cfg_r <= CFG_W'(1);
      cols_cfg_r <= CFG_W'(2);
      pos_r <= '0; lrow_r <= '0; lcol_r <= '0;
      sing_r <= 1'b0; ph_r <= '0; k_r <= '0; i_r <= '0;
      nr_r <= RW'(1); nc_r <= CW'(2);
    end else begin
      st_r <= st_nxt;
      if (cfg_we && cfg_index == CFG_ROWS) rows_cfg_r <= cfg_data;
      if (cfg_we && cfg_index == CFG_COLS) cols_cfg_r <= cfg_data;
      pos_r <= pos_nxt; lrow_r <= lrow_nxt; lcol_r <= lcol_nxt;
      sing_r <= sing_nxt; ph_r <= ph_nxt; k_r <= k_nxt; i_r <= i_nxt;
      nr_r <= nr_nxt; nc_r <= nc_nxt;
    end
    best_r <= best_nxt; l_r <= l_nxt; bmag_r <= bmag_nxt;
  end

endmodule

FILE: src/gjs_elim_fix.sv
module gjs_elim_fix
  import gjs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    capture,
  input  logic signed [VAL_W-1:0] rd_q,
  output logic signed [VAL_W-1:0] out_q
);

  logic signed [VAL_W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) q_r <= '0;
    else if (capture) q_r <= rd_q;
  end

  assign out_q = q_r;

endmodule

FILE: src/gauss_jordan_solver_core.sv
// channel  dir  fields                                          accepted when
// in       in   element_value, last_element                     in.valid & in.ready
// out      out  solution_value, row_index, last_result, singular out.valid & out.ready
// cfg      in   cfg_we, cfg_index, cfg_data                     cfg_we high
// Elements load one per cycle while in.ready is high; after a shape change in stays
// low while the load position is split into row and column. The solve does one memory
// access per cycle and waits on the divider for each division; a row swap adds to the
// cost of a pivot step. Each result is read from memory before it is offered, and
// waits in the output register until taken.
// Reset is synchronous; the matrix memory is not cleared.
module gauss_jordan_solver_core
  import gjs_pkg::*;
#(
  parameter int unsigned MAX_ROWS    = DEF_MAX_ROWS,
  parameter int unsigned MAX_COLUMNS = DEF_MAX_COLUMNS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  gjs_in_if.sink               in_if,
  gjs_out_if.source            out_if
);

  localparam int unsigned AW = $clog2(MAX_ROWS*MAX_COLUMNS);

  dp_op_t                  op;
  logic [AW-1:0]           addr;
  logic signed [VAL_W-1:0] a_q, b_q, rd_q, res_q;
  logic                    dp_busy;
  logic                    ld;
  logic                    out_valid;

  gjs_ctrl #(.MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .in_last   (in_if.last_element),
    .out_valid (out_valid),
    .out_ready (out_if.ready),
    .out_row   (out_if.row_index),
    .out_last  (out_if.last_result),
    .out_sing  (out_if.singular),
    .out_load  (ld),
    .op        (op),
    .addr      (addr),
    .a_q       (a_q),
    .b_q       (b_q),
    .rd_q      (rd_q),
    .dp_busy   (dp_busy)
  );

  gjs_datapath #(.MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS)) u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (op),
    .addr  (addr),
    .din   (in_if.element_value),
    .a_q   (a_q),
    .b_q   (b_q),
    .rd_q  (rd_q),
    .busy  (dp_busy)
  );

  gjs_elim_fix u_res (
    .clk     (clk),
    .rst_n   (rst_n),
    .capture (!out_valid && !ld),
    .rd_q    (rd_q),
    .out_q   (res_q)
  );

  assign out_if.valid          = out_valid;
  assign out_if.solution_value = res_q;

endmodule
